### rtl/hvd_pkg.sv
// Shared types, constants and helper functions for the haversine distance core.
package hvd_pkg;

   localparam int LANES       = 4;
   localparam int DIV_STEPS   = 12;
   localparam int ROT_STEPS   = 30;
   localparam int SQRT_STEPS  = 31;
   localparam int LAST_STAGE  = 112;

   localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
   localparam logic [32:0]        RANGE_SCALE  = 33'd5129602136;
   localparam logic [28:0]        RANGE_MAX    = 29'd320600134;
   localparam logic [5:0]         DIV_BASE     = 6'd45;

   typedef logic signed [33:0] word_type;
   typedef logic signed [63:0] prod_type;

   typedef enum logic [1:0] {
      Q_EAST  = 2'd0,
      Q_NORTH = 2'd1,
      Q_WEST  = 2'd2,
      Q_SOUTH = 2'd3
   } quad_type;

   // atan(2^-i) in turns times 2^32
   function automatic logic [29:0] atan_turn(input logic [4:0] idx);
      logic [29:0] v;
      unique case (idx)
         5'd0:  v = 30'h20000000;
         5'd1:  v = 30'h12E4051E;
         5'd2:  v = 30'h09FB385B;
         5'd3:  v = 30'h051111D4;
         5'd4:  v = 30'h028B0D43;
         5'd5:  v = 30'h0145D7E1;
         5'd6:  v = 30'h00A2F61E;
         5'd7:  v = 30'h00517C55;
         5'd8:  v = 30'h0028BE53;
         5'd9:  v = 30'h00145F2F;
         5'd10: v = 30'h000A2F98;
         5'd11: v = 30'h000517CC;
         5'd12: v = 30'h00028BE6;
         5'd13: v = 30'h000145F3;
         5'd14: v = 30'h0000A2FA;
         5'd15: v = 30'h0000517D;
         5'd16: v = 30'h000028BE;
         5'd17: v = 30'h0000145F;
         5'd18: v = 30'h00000A30;
         5'd19: v = 30'h00000518;
         5'd20: v = 30'h0000028C;
         5'd21: v = 30'h00000146;
         5'd22: v = 30'h000000A3;
         5'd23: v = 30'h00000051;
         5'd24: v = 30'h00000029;
         5'd25: v = 30'h00000014;
         5'd26: v = 30'h0000000A;
         5'd27: v = 30'h00000005;
         5'd28: v = 30'h00000003;
         5'd29: v = 30'h00000001;
         default: v = 30'h0;
      endcase
      return v;
   endfunction

   // one radix-16 digit of a division by 45: returns {quotient digit, remainder}
   function automatic logic [9:0] div_digit(input logic [9:0] x);
      logic [9:0] r;
      logic [3:0] q;
      r = x;
      q = '0;
      for (int k = 3; k >= 0; k--) begin
         if (r >= (10'(DIV_BASE) << k)) begin
            r    = r - (10'(DIV_BASE) << k);
            q[k] = 1'b1;
         end
      end
      return {q, r[5:0]};
   endfunction

endpackage

### rtl/haversine_distance_core.sv
// Haversine great-circle distance core: fully pipelined CORDIC datapath.
// Throughput: one item per cycle; the whole pipe advances while the output
// register is empty or being taken, and holds as a unit on a stall.
// Reset: synchronous, active high; clears all valid bits, payload is not reset.
module haversine_distance_core #(
   parameter int ANGLE_FRAC_BITS = 22
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [29:0] req_lat_a,
   input  logic signed [30:0] req_lon_a,
   input  logic signed [29:0] req_lat_b,
   input  logic signed [30:0] req_lon_b,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [28:0]        rsp_range_sixteenths
);

   localparam int PHASE_SHIFT = 32 - ANGLE_FRAC_BITS;
   localparam int NL = hvd_pkg::LANES;
   localparam int ND = hvd_pkg::DIV_STEPS;
   localparam int NR = hvd_pkg::ROT_STEPS;
   localparam int NS = hvd_pkg::SQRT_STEPS;
   localparam int NV = hvd_pkg::LAST_STAGE;

   logic en;

   logic vld_ff [0:NV];
   logic vld_in [0:NV];
   logic zer_ff [0:NV];
   logic zer_in [0:NV];

   logic [47:0] dnum_ff [0:ND][NL];
   logic [47:0] dnum_in [0:ND][NL];
   logic [5:0]  drem_ff [0:ND][NL];
   logic [5:0]  drem_in [0:ND][NL];
   logic [31:0] dquo_ff [0:ND][NL];
   logic [31:0] dquo_in [0:ND][NL];

   hvd_pkg::word_type rx_ff [0:NR][NL];
   hvd_pkg::word_type rx_in [0:NR][NL];
   hvd_pkg::word_type ry_ff [0:NR][NL];
   hvd_pkg::word_type ry_in [0:NR][NL];
   hvd_pkg::word_type rz_ff [0:NR][NL];
   hvd_pkg::word_type rz_in [0:NR][NL];
   hvd_pkg::quad_type qd_ff [0:NR][NL];
   hvd_pkg::quad_type qd_in [0:NR][NL];

   hvd_pkg::word_type sc_ff [NL];
   hvd_pkg::word_type sc_in [NL];

   hvd_pkg::prod_type pcc_ff, pcc_in, pss1_ff, pss1_in;
   hvd_pkg::prod_type pt_ff, pt_in, pss2_ff, pss2_in;
   hvd_pkg::prod_type pts_ff, pts_in, pss3_ff, pss3_in;
   hvd_pkg::word_type s2a_ff, s2a_in, s2b_ff, s2b_in;

   logic [61:0] sqn_ff [0:NS][2];
   logic [61:0] sqn_in [0:NS][2];
   logic [33:0] sqr_ff [0:NS][2];
   logic [33:0] sqr_in [0:NS][2];
   logic [30:0] sqt_ff [0:NS][2];
   logic [30:0] sqt_in [0:NS][2];

   hvd_pkg::word_type vx_ff [0:NR];
   hvd_pkg::word_type vx_in [0:NR];
   hvd_pkg::word_type vy_ff [0:NR];
   hvd_pkg::word_type vy_in [0:NR];
   hvd_pkg::word_type vz_ff [0:NR];
   hvd_pkg::word_type vz_in [0:NR];
   logic              sz_ff [0:NR];
   logic              sz_in [0:NR];

   logic [48:0] pl_ff, pl_in;
   logic [47:0] ph_ff, ph_in;
   logic [28:0] rng_ff, rng_in;

   assign en                   = !vld_ff[NV] || rsp_ready;
   assign req_ready            = en;
   assign rsp_valid            = vld_ff[NV];
   assign rsp_range_sixteenths = rng_ff;

   // valid and identical-point flags
   always_comb begin
      vld_in[0] = req_valid;
      zer_in[0] = (req_lat_a == req_lat_b) && (req_lon_a == req_lon_b);
      for (int k = 1; k <= NV; k++) begin
         vld_in[k] = vld_ff[k-1];
         zer_in[k] = zer_ff[k-1];
      end
   end

   // angle to phase: offset numerator, then radix-16 division by 45
   always_comb begin
      logic signed [31:0] ang [NL];
      logic signed [49:0] nfull;
      logic [9:0]         dig;
      ang[0] = 32'(req_lat_a) - 32'(req_lat_b);
      ang[1] = 32'(req_lon_a) - 32'(req_lon_b);
      ang[2] = 32'(req_lat_a);
      ang[3] = 32'(req_lon_b) - 32'(req_lon_b) + 32'(req_lat_b);
      for (int l = 0; l < NL; l++) begin
         nfull = (50'(ang[l]) <<< PHASE_SHIFT) + ((l < 2) ? 50'sd360 : 50'sd180)
                 + (50'sd45 <<< 42);
         dnum_in[0][l] = (l < 2) ? 48'(nfull[48:4]) : 48'(nfull[48:3]);
         drem_in[0][l] = '0;
         dquo_in[0][l] = '0;
      end
      for (int j = 0; j < ND; j++) begin
         for (int l = 0; l < NL; l++) begin
            dig = hvd_pkg::div_digit({drem_ff[j][l], dnum_ff[j][l][47:44]});
            dnum_in[j+1][l] = {dnum_ff[j][l][43:0], 4'b0};
            drem_in[j+1][l] = dig[5:0];
            dquo_in[j+1][l] = {dquo_ff[j][l][27:0], dig[9:6]};
         end
      end
   end

   // quadrant split and rotation CORDIC
   always_comb begin
      logic [31:0] ph;
      logic [31:0] res;
      logic [31:0] qsum;
      hvd_pkg::word_type xs, ys, at;
      for (int l = 0; l < NL; l++) begin
         ph   = (l < 2) ? {1'b0, dquo_ff[ND][l][30:0]} : dquo_ff[ND][l];
         qsum = ph + 32'h2000_0000;
         qd_in[0][l] = hvd_pkg::quad_type'(qsum[31:30]);
         res  = ph - {qsum[31:30], 30'b0};
         rx_in[0][l] = hvd_pkg::CORDIC_START;
         ry_in[0][l] = '0;
         rz_in[0][l] = 34'($signed(res));
      end
      for (int k = 0; k < NR; k++) begin
         at = $signed({4'b0, hvd_pkg::atan_turn(5'(k))});
         for (int l = 0; l < NL; l++) begin
            xs = rx_ff[k][l] >>> k;
            ys = ry_ff[k][l] >>> k;
            qd_in[k+1][l] = qd_ff[k][l];
            if (!rz_ff[k][l][33]) begin
               rx_in[k+1][l] = rx_ff[k][l] - ys;
               ry_in[k+1][l] = ry_ff[k][l] + xs;
               rz_in[k+1][l] = rz_ff[k][l] - at;
            end else begin
               rx_in[k+1][l] = rx_ff[k][l] + ys;
               ry_in[k+1][l] = ry_ff[k][l] - xs;
               rz_in[k+1][l] = rz_ff[k][l] + at;
            end
         end
      end
   end

   // quadrant fold: lanes 0,1 give sine, lanes 2,3 give cosine
   always_comb begin
      hvd_pkg::word_type x, y;
      for (int l = 0; l < NL; l++) begin
         x = rx_ff[NR][l];
         y = ry_ff[NR][l];
         if (l < 2) begin
            unique case (qd_ff[NR][l])
               hvd_pkg::Q_EAST:  sc_in[l] = y;
               hvd_pkg::Q_NORTH: sc_in[l] = x;
               hvd_pkg::Q_WEST:  sc_in[l] = -y;
               hvd_pkg::Q_SOUTH: sc_in[l] = -x;
               default:          sc_in[l] = y;
            endcase
         end else begin
            unique case (qd_ff[NR][l])
               hvd_pkg::Q_EAST:  sc_in[l] = x;
               hvd_pkg::Q_NORTH: sc_in[l] = -y;
               hvd_pkg::Q_WEST:  sc_in[l] = -x;
               hvd_pkg::Q_SOUTH: sc_in[l] = y;
               default:          sc_in[l] = x;
            endcase
         end
      end
   end

   // haversine term
   always_comb begin
      hvd_pkg::word_type cc, t;
      hvd_pkg::prod_type a;
      logic [60:0]       au;
      pcc_in  = 64'(sc_ff[2]) * 64'(sc_ff[3]);
      pss1_in = 64'(sc_ff[0]) * 64'(sc_ff[0]);
      s2a_in  = sc_ff[1];

      cc      = 34'((pcc_ff + 64'sd536870912) >>> 30);
      pt_in   = 64'(cc) * 64'(s2a_ff);
      pss2_in = pss1_ff;
      s2b_in  = s2a_ff;

      t       = 34'((pt_ff + 64'sd536870912) >>> 30);
      pts_in  = 64'(t) * 64'(s2b_ff);
      pss3_in = pss2_ff;

      a = pss3_ff + pts_ff;
      priority if (a[63])
         au = '0;
      else if (a > (64'sd1 <<< 60))
         au = 61'(1) << 60;
      else
         au = a[60:0];
      sqn_in[0][0] = {1'b0, au};
      sqn_in[0][1] = (62'(1) << 60) - 62'(au);
      for (int l = 0; l < 2; l++) begin
         sqr_in[0][l] = '0;
         sqt_in[0][l] = '0;
      end
   end

   // digit-by-digit square roots of a and 1-a
   always_comb begin
      logic [33:0] r2, trial;
      for (int k = 0; k < NS; k++) begin
         for (int l = 0; l < 2; l++) begin
            r2    = {sqr_ff[k][l][31:0], sqn_ff[k][l][61:60]};
            trial = {1'b0, sqt_ff[k][l], 2'b01};
            sqn_in[k+1][l] = {sqn_ff[k][l][59:0], 2'b00};
            if (r2 >= trial) begin
               sqr_in[k+1][l] = r2 - trial;
               sqt_in[k+1][l] = {sqt_ff[k][l][29:0], 1'b1};
            end else begin
               sqr_in[k+1][l] = r2;
               sqt_in[k+1][l] = {sqt_ff[k][l][29:0], 1'b0};
            end
         end
      end
   end

   // vectoring CORDIC for asin
   always_comb begin
      hvd_pkg::word_type xs, ys, at;
      vx_in[0] = 34'($signed({1'b0, sqt_ff[NS][1]}));
      vy_in[0] = 34'($signed({1'b0, sqt_ff[NS][0]}));
      vz_in[0] = '0;
      sz_in[0] = (sqt_ff[NS][0] == '0);
      for (int k = 0; k < NR; k++) begin
         at = $signed({4'b0, hvd_pkg::atan_turn(5'(k))});
         xs = vx_ff[k] >>> k;
         ys = vy_ff[k] >>> k;
         sz_in[k+1] = sz_ff[k];
         if (!vy_ff[k][33]) begin
            vx_in[k+1] = vx_ff[k] + ys;
            vy_in[k+1] = vy_ff[k] - xs;
            vz_in[k+1] = vz_ff[k] + at;
         end else begin
            vx_in[k+1] = vx_ff[k] - ys;
            vy_in[k+1] = vy_ff[k] + xs;
            vz_in[k+1] = vz_ff[k] - at;
         end
      end
   end

   // angle clamp and scaling to 1/16 m
   always_comb begin
      logic [30:0] zc;
      logic [64:0] sum;
      logic [30:0] d;
      priority if (sz_ff[NR] || vz_ff[NR][33])
         zc = '0;
      else if (vz_ff[NR] > (34'sd1 <<< 30))
         zc = 31'(1) << 30;
      else
         zc = vz_ff[NR][30:0];
      pl_in = 49'(zc[15:0]) * 49'(hvd_pkg::RANGE_SCALE);
      ph_in = 48'(zc[30:16]) * 48'(hvd_pkg::RANGE_SCALE);

      sum = (65'(ph_ff) << 16) + 65'(pl_ff) + (65'(1) << 33);
      d   = sum[64:34];
      priority if (zer_ff[NV-1])
         rng_in = '0;
      else if (d > 31'(hvd_pkg::RANGE_MAX))
         rng_in = hvd_pkg::RANGE_MAX;
      else
         rng_in = d[28:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= NV; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zer_ff  <= zer_in;
         dnum_ff <= dnum_in;
         drem_ff <= drem_in;
         dquo_ff <= dquo_in;
         rx_ff   <= rx_in;
         ry_ff   <= ry_in;
         rz_ff   <= rz_in;
         qd_ff   <= qd_in;
         sc_ff   <= sc_in;
         pcc_ff  <= pcc_in;
         pss1_ff <= pss1_in;
         s2a_ff  <= s2a_in;
         pt_ff   <= pt_in;
         pss2_ff <= pss2_in;
         s2b_ff  <= s2b_in;
         pts_ff  <= pts_in;
         pss3_ff <= pss3_in;
         sqn_ff  <= sqn_in;
         sqr_ff  <= sqr_in;
         sqt_ff  <= sqt_in;
         vx_ff   <= vx_in;
         vy_ff   <= vy_in;
         vz_ff   <= vz_in;
         sz_ff   <= sz_in;
         pl_ff   <= pl_in;
         ph_ff   <= ph_in;
         rng_ff  <= rng_in;
      end
   end

endmodule

### tb/haversine_distance_checker.sv
`timescale 1ns / 100ps
// Range checker: predicts each distance from the accepted coordinate pair and compares.
module haversine_distance_checker #(
   parameter int FRAC = 22
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic signed [29:0] req_lat_a,
   input  logic signed [30:0] req_lon_a,
   input  logic signed [29:0] req_lat_b,
   input  logic signed [30:0] req_lon_b,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [28:0]        rsp_range_sixteenths,
   output int                 errors,
   output int                 pending
);

   localparam longint    ONE_Q30  = longint'(1) << 30;
   localparam longint    ONE_Q60  = longint'(1) << 60;
   localparam longint    GAIN_X0  = 652032874;
   localparam longint unsigned SCALE = 64'd5129602136;
   localparam logic [28:0] SAT    = 29'd320600134;

   localparam longint arc_step [30] = '{
      'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43,
      'h0145D7E1, 'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F,
      'h000A2F98, 'h000517CC, 'h00028BE6, 'h000145F3, 'h0000A2FA,
      'h0000517D, 'h000028BE, 'h0000145F, 'h00000A30, 'h00000518,
      'h0000028C, 'h00000146, 'h000000A3, 'h00000051, 'h00000029,
      'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001
   };

   logic [28:0] range_queue [$];

   function automatic logic [31:0] angle_turns(input longint v, input longint unsigned div);
      longint full;
      longint r;
      longint unsigned num;
      full = longint'(360) << FRAC;
      r = v % full;
      if (r < 0) r += full;
      num = (longint'(r) << (32 - FRAC)) + div / 2;
      return 32'(num / div);
   endfunction

   function automatic void rotate(input logic [31:0] p, output longint cv, output longint sv);
      logic [1:0]  q;
      logic [31:0] res;
      longint x, y, z, nx;
      q   = 2'(((p + 32'h20000000) >> 30) & 32'd3);
      res = p - (32'(q) << 30);
      z   = longint'(res);
      if (res[31]) z -= longint'(1) << 32;
      x = GAIN_X0;
      y = 0;
      for (int i = 0; i < 30; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z -= arc_step[i];
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z += arc_step[i];
         end
         x = nx;
      end
      case (q)
         2'd0: begin cv = x;  sv = y;  end
         2'd1: begin cv = -y; sv = x;  end
         2'd2: begin cv = -x; sv = -y; end
         default: begin cv = y; sv = -x; end
      endcase
   endfunction

   function automatic longint unsigned int_root(input longint unsigned n);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n  -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint arc_angle(input longint x, input longint y);
      longint z, nx;
      z = 0;
      for (int i = 0; i < 30; i++) begin
         if (y >= 0) begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z += arc_step[i];
         end else begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z -= arc_step[i];
         end
         x = nx;
      end
      return z;
   endfunction

   function automatic logic [28:0] great_circle_range(input longint la, input longint oa,
                                                      input longint lb, input longint ob);
      longint dlat, dlon, s1, s2, c1, c2, dummy, cc, t, a, sa, ca, z;
      longint unsigned d;
      dlat = la - lb;
      dlon = oa - ob;
      if (dlat == 0 && dlon == 0) return '0;
      rotate(angle_turns(dlat, 720), dummy, s1);
      rotate(angle_turns(dlon, 720), dummy, s2);
      rotate(angle_turns(la, 360), c1, dummy);
      rotate(angle_turns(lb, 360), c2, dummy);
      cc = (c1 * c2 + (ONE_Q30 >> 1)) >>> 30;
      t  = (cc * s2 + (ONE_Q30 >> 1)) >>> 30;
      a  = s1 * s1 + t * s2;
      if (a < 0) a = 0;
      if (a > ONE_Q60) a = ONE_Q60;
      sa = longint'(int_root(longint'(a)));
      ca = longint'(int_root(longint'(ONE_Q60 - a)));
      z  = (sa == 0) ? 0 : arc_angle(ca, sa);
      if (z < 0) z = 0;
      if (z > ONE_Q30) z = ONE_Q30;
      d = (longint'(z) * SCALE + (64'd1 << 33)) >> 34;
      if (d > 64'(SAT)) d = 64'(SAT);
      return 29'(d);
   endfunction

   initial errors = 0;
   assign pending = range_queue.size();

   always @(posedge clock) begin
      logic [28:0] want;
      if (!reset) begin
         if (req_valid && req_ready)
            range_queue.push_back(great_circle_range(longint'(req_lat_a), longint'(req_lon_a),
                                                     longint'(req_lat_b), longint'(req_lon_b)));
         if (rsp_valid && rsp_ready) begin
            if (range_queue.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected item: range_sixteenths=%0d", rsp_range_sixteenths);
            end else begin
               want = range_queue.pop_front();
               if (want !== rsp_range_sixteenths) begin
                  errors++;
                  if (errors <= 10)
                     $display("range_sixteenths mismatch: expected %0d, got %0d",
                              want, rsp_range_sixteenths);
               end
            end
         end
      end
   end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// Top of the haversine distance testbench: clock, reset, coordinate stimulus and verdict.
module testbench;

   localparam int LAT_MAX   = 377487360;
   localparam int LON_MAX   = 754974720;
   localparam int STALL_CAP = 5000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [29:0] req_lat_a = '0;
   logic signed [30:0] req_lon_a = '0;
   logic signed [29:0] req_lat_b = '0;
   logic signed [30:0] req_lon_b = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [28:0]        rsp_range_sixteenths;
   int                 errors;
   int                 pending;
   int                 send_idle_pct = 0;
   int                 recv_stall_pct = 0;
   int                 quiet_cycles = 0;

   always #10 clock = ~clock;

   haversine_distance_core i_dut (.*);

   haversine_distance_checker i_checker (.*);

   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_CAP) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic send_pair(input logic signed [29:0] la, input logic signed [30:0] oa,
                            input logic signed [29:0] lb, input logic signed [30:0] ob);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_lat_a <= la;
      req_lon_a <= oa;
      req_lat_b <= lb;
      req_lon_b <= ob;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_coords(input int la, input int oa, input int lb, input int ob);
      send_pair(30'(la), 31'(oa), 30'(lb), 31'(ob));
   endtask

   function automatic logic signed [29:0] any_lat();
      return 30'(int'($urandom_range(2 * LAT_MAX)) - LAT_MAX);
   endfunction

   function automatic logic signed [30:0] any_lon();
      return 31'(longint'($urandom_range(2 * LON_MAX)) - LON_MAX);
   endfunction

   task automatic random_pair();
      logic signed [29:0] la, lb;
      logic signed [30:0] oa, ob;
      int pick;
      pick = $urandom_range(99);
      la = any_lat();
      oa = any_lon();
      if (pick < 55) begin
         lb = any_lat();
         ob = any_lon();
      end else if (pick < 70) begin
         lb = la + 30'($urandom_range(255)) - 30'd128;
         ob = oa + 31'($urandom_range(255)) - 31'd128;
      end else if (pick < 80) begin
         lb = -la + 30'($urandom_range(63)) - 30'd32;
         ob = oa + 31'(LON_MAX / 2) + 31'($urandom_range(63)) - 31'd32;
      end else if (pick < 85) begin
         lb = la;
         ob = oa;
      end else begin
         la = 30'($urandom);
         oa = 31'($urandom);
         lb = 30'($urandom);
         ob = 31'($urandom);
      end
      send_pair(la, oa, lb, ob);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // extremes, identical points, antipodes, poles, beyond-pole latitudes, raw bit extremes
      send_coords(0, 0, 0, 0);
      send_coords(LAT_MAX, LON_MAX, LAT_MAX, LON_MAX);
      send_coords(LAT_MAX, 0, -LAT_MAX, 0);
      send_coords(0, 0, 0, LON_MAX / 2);
      send_coords(0, -LON_MAX / 2, 0, LON_MAX / 2);
      send_coords(0, -LON_MAX, 0, LON_MAX);
      send_coords(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX);
      send_coords(1, 0, 0, 0);
      send_coords(0, 1, 0, 0);
      send_coords(LAT_MAX, 0, LAT_MAX, 1);
      send_coords(LAT_MAX, 5, LAT_MAX, -LON_MAX);
      send_pair(30'sh1FFFFFFF, 31'sh3FFFFFFF, 30'sh20000000, 31'sh40000000);
      send_pair(30'sh20000000, 31'sh40000000, 30'sh1FFFFFFF, 31'sh3FFFFFFF);
      send_pair(30'sh3FFFFFFF, 31'sh7FFFFFFF, '0, '0);
      send_coords(LAT_MAX - 1000, 0, LAT_MAX + 1000, 0);
      send_coords(-LAT_MAX - 4000, 123, LAT_MAX + 4000, LON_MAX / 2);
      send_coords(LAT_MAX / 2, LON_MAX / 4, -LAT_MAX / 2, -LON_MAX * 3 / 4);
      send_coords(-LAT_MAX / 3, 77, -LAT_MAX / 3, 78);
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
            default: begin send_idle_pct = 10; recv_stall_pct = 10; end
         endcase
         repeat (470) random_pair();
      end
      req_valid <= 1'b0;
      recv_stall_pct = 0;
      while (pending != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (errors == 0 && pending == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
